@@ design/gf2pm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2pm_pkg: shared constants and helpers for the GF(2) polynomial multiplier
// Word width, pipeline geometry and the degree encoder used by the datapath.
// ----------------------------------------------------------------------------
package gf2pm_pkg;

    // Polynomial word width; bit i holds the coefficient of x^i.
    localparam int WIDTH = 64;

    // Width of a degree value (0 .. WIDTH-1).
    localparam int DEG_W = $clog2(WIDTH);

    // Width of a reduction step count (0 .. WIDTH).
    localparam int N_W = $clog2(WIDTH + 1);

    // Partial products folded per group in the first multiply stage.
    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (WIDTH + GROUP_SIZE - 1) / GROUP_SIZE;

    // Long-division steps done in each reduction stage.
    localparam int STEPS      = 8;
    localparam int RED_STAGES = (WIDTH + STEPS - 1) / STEPS;

    // Pipeline stages from start to done: two multiply stages, the reduction
    // stages and the final alignment stage.
    localparam int LATENCY = 2 + RED_STAGES + 1;

    // Index of the highest set bit; zero for the zero polynomial, so the
    // caller checks for zero separately.
    function automatic logic [DEG_W-1:0] poly_degree(input logic [WIDTH-1:0] p);
        logic [DEG_W-1:0] deg;
        deg = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (p[i])
            begin
                deg = DEG_W'(i);
            end
        end
        return deg;
    endfunction

endpackage

@@ design/gf2_poly_multiply_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_multiply_mod: pipelined carry-less multiply with modular reduction
// Multiplies two GF(2) polynomials and reduces the product by a modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: operand_a and operand_b are taken at a clock edge with start
//   high and busy low. busy is always low, so a new beat may enter on every
//   cycle; the block holds no state between beats.
//   Result beat: product and overflow are valid for one cycle while done is
//   high. done follows its start through the pipeline stages that
//   gf2pm_pkg::LATENCY counts: two stages build the carry-less product,
//   eight stages each run up to eight steps of the long division by the
//   modulus, and one stage realigns the remainder. Throughput is one beat per cycle.
//   overflow is set, with a zero product, when the operand degrees sum past
//   63. A zero modulus passes the plain product through.
//   Configuration: modulus_poly is written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. Write it only while no beat is in flight.
//   Reset clears the modulus to zero and empties the pipeline.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module gf2_poly_multiply_mod
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         start,
    output logic                         busy,
    input  logic [gf2pm_pkg::WIDTH-1:0]  operand_a,
    input  logic [gf2pm_pkg::WIDTH-1:0]  operand_b,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gf2pm_pkg::WIDTH-1:0]  modulus_poly,

    output logic                         done,
    output logic [gf2pm_pkg::WIDTH-1:0]  product,
    output logic                         overflow
);

    localparam int W   = gf2pm_pkg::WIDTH;
    localparam int DW  = gf2pm_pkg::DEG_W;
    localparam int NW  = gf2pm_pkg::N_W;
    localparam int GS  = gf2pm_pkg::GROUP_SIZE;
    localparam int NG  = gf2pm_pkg::GROUPS;
    localparam int ST  = gf2pm_pkg::STEPS;
    localparam int NRS = gf2pm_pkg::RED_STAGES;

    // Modulus shifted so its leading one sits at the top bit, and the number
    // of division steps (WIDTH - degree, zero when reduction is off).
    logic [W-1:0]  mtop_reg;
    logic [W-1:0]  mtop_next;
    logic [NW-1:0] nsteps_reg;
    logic [NW-1:0] nsteps_next;
    logic [DW-1:0] cfg_deg;

    logic          accept;

    // Stage 1: grouped partial products and overflow flag.
    logic          s1_valid_reg;
    logic          s1_ovf_reg;
    logic          s1_ovf_next;
    logic [W-1:0]  grp_reg  [NG];
    logic [W-1:0]  grp_next [NG];
    logic [DW-1:0] deg_a;
    logic [DW-1:0] deg_b;
    logic [DW:0]   deg_sum;

    // Stage 2: full product, forced to zero on overflow.
    logic          s2_valid_reg;
    logic          s2_ovf_reg;
    logic [W-1:0]  s2_prod_reg;
    logic [W-1:0]  s2_prod_next;

    // Reduction stages.
    logic          red_valid_reg [NRS];
    logic          red_ovf_reg   [NRS];
    logic [W-1:0]  red_w_reg     [NRS];
    logic [W-1:0]  red_w_next    [NRS];
    logic [W-1:0]  red_in_w      [NRS];

    // Output stage.
    logic          done_reg;
    logic          ovf_out_reg;
    logic [W-1:0]  prod_out_reg;
    logic [W-1:0]  prod_out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // Normalize the modulus when it is written.
    always_comb
    begin
        cfg_deg   = gf2pm_pkg::poly_degree(modulus_poly);
        mtop_next = modulus_poly << (DW'(W - 1) - cfg_deg);
        if (modulus_poly == '0)
        begin
            nsteps_next = '0;
        end
        else
        begin
            nsteps_next = NW'(W) - NW'(cfg_deg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtop_reg   <= '0;
            nsteps_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mtop_reg   <= mtop_next;
            nsteps_reg <= nsteps_next;
        end
    end

    // Stage 1 logic: each group folds GROUP_SIZE shifted copies of operand_b.
    always_comb
    begin
        deg_a   = gf2pm_pkg::poly_degree(operand_a);
        deg_b   = gf2pm_pkg::poly_degree(operand_b);
        deg_sum = {1'b0, deg_a} + {1'b0, deg_b};
        s1_ovf_next = (operand_a != '0) && (operand_b != '0) &&
                      (deg_sum > (DW+1)'(W - 1));
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GS; j++)
            begin
                if ((g * GS + j) < W)
                begin
                    if (operand_a[g * GS + j])
                    begin
                        grp_next[g] = grp_next[g] ^ (operand_b << (g * GS + j));
                    end
                end
            end
        end
    end

    // Stage 2 logic: combine the groups.
    always_comb
    begin
        s2_prod_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            s2_prod_next = s2_prod_next ^ grp_reg[g];
        end
        if (s1_ovf_reg)
        begin
            s2_prod_next = '0;
        end
    end

    // Reduction logic: each step clears the top bit with the aligned modulus
    // and shifts left, as long as the step count of the modulus allows.
    always_comb
    begin
        red_in_w[0] = s2_prod_reg;
        for (int s = 1; s < NRS; s++)
        begin
            red_in_w[s] = red_w_reg[s-1];
        end
        for (int s = 0; s < NRS; s++)
        begin
            red_w_next[s] = red_in_w[s];
            for (int k = 0; k < ST; k++)
            begin
                if (nsteps_reg > NW'(s * ST + k))
                begin
                    if (red_w_next[s][W-1])
                    begin
                        red_w_next[s] = red_w_next[s] ^ mtop_reg;
                    end
                    red_w_next[s] = red_w_next[s] << 1;
                end
            end
        end
    end

    // Output logic: undo the shifts done by the division steps.
    assign prod_out_next = red_w_reg[NRS-1] >> nsteps_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int s = 0; s < NRS; s++)
            begin
                red_valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept;
            s2_valid_reg     <= s1_valid_reg;
            red_valid_reg[0] <= s2_valid_reg;
            for (int s = 1; s < NRS; s++)
            begin
                red_valid_reg[s] <= red_valid_reg[s-1];
            end
            done_reg <= red_valid_reg[NRS-1];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_ovf_reg <= s1_ovf_next;
        for (int g = 0; g < NG; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
        s2_ovf_reg     <= s1_ovf_reg;
        s2_prod_reg    <= s2_prod_next;
        red_ovf_reg[0] <= s2_ovf_reg;
        for (int s = 1; s < NRS; s++)
        begin
            red_ovf_reg[s] <= red_ovf_reg[s-1];
        end
        for (int s = 0; s < NRS; s++)
        begin
            red_w_reg[s] <= red_w_next[s];
        end
        ovf_out_reg  <= red_ovf_reg[NRS-1];
        prod_out_reg <= prod_out_next;
    end

    assign done     = done_reg;
    assign product  = prod_out_reg;
    assign overflow = ovf_out_reg;

    // Assertions.
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> product == '0)
        else $error("overflow result carries a nonzero product");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(gf2pm_pkg::LATENCY) done)
        else $error("accepted beat did not complete after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, gf2pm_pkg::LATENCY))
        else $error("result without a matching accepted beat");

    a_mod_norm: assert property (@(posedge clk) disable iff (!rst_n)
        nsteps_reg != '0 |-> mtop_reg[W-1] && nsteps_reg <= NW'(W))
        else $error("stored modulus is not normalized");

    a_zero_operand: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operand_a == '0 |->
        ##(gf2pm_pkg::LATENCY) done && product == '0 && !overflow)
        else $error("zero operand gave a nonzero result");

endmodule
